FILE: rtl/obrb_pkg.sv
// ----------------------------------------------------------------------------
// obrb_pkg
// types and constants shared by the overwriting byte ring buffer
// ----------------------------------------------------------------------------
`default_nettype none

package obrb_pkg;

  // width of counts, limits and the capacity register
  localparam int CNT_W = 7;

  // configuration register indexes
  localparam int CFG_CAPACITY = 0;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_WRITE      = 2'd0,
    OP_READ       = 2'd1,
    OP_READ_DELIM = 2'd2,
    OP_PURGE      = 2'd3
  } obrb_op_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [7:0]       data_byte;
    logic [CNT_W-1:0] read_limit;
    logic [7:0]       delimiter;
  } obrb_in_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic             last;
    logic [CNT_W-1:0] used_count;
    logic [CNT_W-1:0] free_count;
  } obrb_res_t;

endpackage

`default_nettype wire

FILE: rtl/obrb_store.sv
// ----------------------------------------------------------------------------
// obrb_store
// byte store of the ring buffer: one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module obrb_store #(
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [7:0]               wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [7:0]                    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read every cycle, data lands in the cycle after the address
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/overwriting_byte_ring_buffer.sv
// ----------------------------------------------------------------------------
// overwriting_byte_ring_buffer
// byte ring buffer that overwrites the oldest byte when full, with plain
// reads, reads up to a delimiter, purge and an apb capacity register
// ----------------------------------------------------------------------------
// write, purge and reads that return no byte give one beat in the
//   cycle after start; busy stays low, so such items can follow one a cycle
// a read of n bytes keeps busy high while it emits and gives n beats on
//   consecutive cycles after the emit state and the store read register;
//   a delimiter read first scans m bytes, each with an address state, then a compare state
// reset: buffer empty, capacity 64, store contents undefined; the result side never stalls
`default_nettype none

module overwriting_byte_ring_buffer import obrb_pkg::*; #(
  parameter int STORE_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // command side
  input  wire logic        start,
  input  wire obrb_in_t    cmd_i,
  output logic             busy,
  // result side
  output logic             res_valid_o,
  output obrb_res_t        res_o,
  // apb configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STORE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_EMIT
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cap_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic [IDX_W-1:0] wr_idx_q;
  logic [IDX_W-1:0] ptr_q;      // scan cursor
  logic [CNT_W-1:0] held_q;
  logic [CNT_W-1:0] left_q;     // bytes still to emit
  logic [CNT_W-1:0] cnt_q;      // bytes scanned before the current one
  logic [CNT_W-1:0] nmax_q;     // scan window
  logic [7:0]       delim_q;
  logic             res_v_q;
  logic             res_bv_q;
  logic             res_last_q;

  logic [CNT_W-1:0] cap_eff;
  logic [CNT_W-1:0] n_lim;
  logic [CNT_W-1:0] cnt_inc;
  logic [IDX_W-1:0] wr_next;
  logic [IDX_W-1:0] raddr;
  logic [7:0]       rd_data;
  logic             accept;
  logic             store_we;
  logic             cfg_we;

  // step an index around the slots in use
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] inc;
    inc = CNT_W'(idx) + CNT_W'(1);
    return (inc >= cap) ? '0 : inc[IDX_W-1:0];
  endfunction

  // capacity of zero acts as one, above the store depth acts as the depth
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_q > DEPTH_C) begin
      cap_eff = DEPTH_C;
    end else begin
      cap_eff = cap_q;
    end
  end

  // a read is cut to what the buffer holds
  assign n_lim    = (cmd_i.read_limit < held_q) ? cmd_i.read_limit : held_q;
  assign wr_next  = next_idx(wr_idx_q, cap_eff);
  assign cnt_inc  = cnt_q + CNT_W'(1);
  assign accept   = start && (state_q == ST_IDLE);
  assign store_we = accept && (cmd_i.opcode == OP_WRITE);
  // pready is tied high, so the access phase completes the write
  assign cfg_we   = psel && penable && pwrite && (paddr[2] == 1'(CFG_CAPACITY));

  // the single read port follows the emit pointer or the scan cursor
  assign raddr = (state_q == ST_EMIT) ? rd_idx_q : ptr_q;

  obrb_store #(
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (wr_idx_q),
    .wdata_i (cmd_i.data_byte),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  // sequencer, pointers and result flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cap_q      <= CAP_RESET;
      rd_idx_q   <= '0;
      wr_idx_q   <= '0;
      ptr_q      <= '0;
      held_q     <= '0;
      left_q     <= '0;
      cnt_q      <= '0;
      nmax_q     <= '0;
      delim_q    <= '0;
      res_v_q    <= 1'b0;
      res_bv_q   <= 1'b0;
      res_last_q <= 1'b0;
    end else begin
      res_v_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            delim_q <= cmd_i.delimiter;
            // status-only beat unless a read moves on to scan or emit
            res_v_q    <= 1'b1;
            res_bv_q   <= 1'b0;
            res_last_q <= 1'b1;
            case (obrb_op_e'(cmd_i.opcode))
              OP_WRITE: begin
                wr_idx_q <= wr_next;
                if (held_q >= cap_eff) begin
                  // full: oldest byte is overwritten, read point follows
                  rd_idx_q <= wr_next;
                  held_q   <= cap_eff;
                end else begin
                  held_q <= held_q + CNT_W'(1);
                end
              end
              OP_PURGE: begin
                rd_idx_q <= '0;
                wr_idx_q <= '0;
                held_q   <= '0;
              end
              OP_READ: begin
                if (n_lim != '0) begin
                  res_v_q <= 1'b0;
                  held_q  <= held_q - n_lim;
                  left_q  <= n_lim;
                  state_q <= ST_EMIT;
                end
              end
              OP_READ_DELIM: begin
                if (n_lim != '0) begin
                  res_v_q <= 1'b0;
                  nmax_q  <= n_lim;
                  cnt_q   <= '0;
                  ptr_q   <= rd_idx_q;
                  state_q <= ST_SCAN_RD;
                end
              end
              default: begin
              end
            endcase
          end
          if (cfg_we) begin
            // new capacity also empties the buffer
            cap_q    <= pwdata[CNT_W-1:0];
            rd_idx_q <= '0;
            wr_idx_q <= '0;
            held_q   <= '0;
          end
        end
        ST_SCAN_RD: begin
          state_q <= ST_SCAN_CMP;
        end
        ST_SCAN_CMP: begin
          if ((rd_data == delim_q) || (cnt_inc == nmax_q)) begin
            // match or window exhausted: length is settled
            left_q  <= cnt_inc;
            held_q  <= held_q - cnt_inc;
            state_q <= ST_EMIT;
          end else begin
            cnt_q   <= cnt_inc;
            ptr_q   <= next_idx(ptr_q, cap_eff);
            state_q <= ST_SCAN_RD;
          end
        end
        ST_EMIT: begin
          rd_idx_q   <= next_idx(rd_idx_q, cap_eff);
          left_q     <= left_q - CNT_W'(1);
          res_v_q    <= 1'b1;
          res_bv_q   <= 1'b1;
          res_last_q <= (left_q == CNT_W'(1));
          if (left_q == CNT_W'(1)) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_v_q;

  // counts are settled before the first beat of an item
  always_comb begin
    res_o.out_byte   = res_bv_q ? rd_data : 8'd0;
    res_o.byte_valid = res_bv_q;
    res_o.last       = res_last_q;
    res_o.used_count = held_q;
    res_o.free_count = cap_eff - held_q;
  end

  assign prdata = {{(32 - CNT_W){1'b0}}, cap_q};
  assign pready = 1'b1;

  // fill level never exceeds the slots in use
  a_held_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= cap_eff)
    else $error("held count above capacity");

  // read pointer stays inside the slots in use
  a_rd_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(rd_idx_q) < cap_eff)
    else $error("read index outside capacity");

  // every emit cycle produces a data beat in the next cycle
  a_emit_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |=> (res_valid_o && res_o.byte_valid))
    else $error("emit cycle without data beat");

  // a beat without data always closes its item
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.byte_valid) |-> res_o.last)
    else $error("status beat not marked last");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the overwriting byte ring buffer: a local model of
// the ring predicts every result beat of each accepted command, and the beats
// coming out of the block are compared field by field in arrival order.
// directed commands and capacity corner cases come first, then random traffic
// over several capacity settings with random idle gaps on the command side
// ----------------------------------------------------------------------------

module tb_top;
  import obrb_pkg::*;

  localparam int DEPTH = 64;
  // settle time after the last beat before a register write or the end
  localparam int SETTLE_CYCLES = 8;
  localparam logic [2:0] CAP_ADDR = 3'(CFG_CAPACITY * 4);

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  obrb_in_t    cmd_i;
  logic        busy;
  logic        res_valid_o;
  obrb_res_t   res_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  overwriting_byte_ring_buffer #(
    .STORE_DEPTH(DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .cmd_i      (cmd_i),
    .busy       (busy),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // --------------------------------------------------------------------------
  // ring model: its own copy of the store, pointers, fill level and capacity
  // --------------------------------------------------------------------------
  logic [7:0]       ring_mem [DEPTH];
  int               rd_ptr = 0;
  int               wr_ptr = 0;
  int               fill = 0;
  logic [CNT_W-1:0] cap_reg = CAP_RESET;

  // beats still owed by the block, oldest first
  obrb_res_t        pending_beats[$];
  int               errors = 0;

  function automatic int step_ptr(int p, int cap);
    return (p + 1 >= cap) ? 0 : p + 1;
  endfunction

  // counts always reflect the state after the whole command
  function automatic obrb_res_t count_beat(logic [7:0] b, logic v, logic l, int cap);
    obrb_res_t r;
    r.out_byte   = b;
    r.byte_valid = v;
    r.last       = l;
    r.used_count = CNT_W'(fill);
    r.free_count = CNT_W'(cap - fill);
    return r;
  endfunction

  function automatic void predict_cmd(obrb_in_t c);
    int cap;
    int n;
    int idx;
    logic [7:0] taken [DEPTH];
    // zero acts as one, anything above the store depth as the depth
    cap = (cap_reg == 0) ? 1 : ((int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg));
    if (rd_ptr >= cap) rd_ptr = 0;
    if (wr_ptr >= cap) wr_ptr = 0;
    if (fill > cap) fill = cap;
    case (obrb_op_e'(c.opcode))
      OP_WRITE: begin
        ring_mem[wr_ptr] = c.data_byte;
        wr_ptr = step_ptr(wr_ptr, cap);
        // full: oldest byte is lost, read point follows the write point
        if (fill >= cap) begin
          rd_ptr = wr_ptr;
          fill = cap;
        end else begin
          fill++;
        end
        pending_beats.push_back(count_beat(8'h00, 1'b0, 1'b1, cap));
      end
      OP_PURGE: begin
        rd_ptr = 0;
        wr_ptr = 0;
        fill = 0;
        pending_beats.push_back(count_beat(8'h00, 1'b0, 1'b1, cap));
      end
      default: begin
        n = (int'(c.read_limit) < fill) ? int'(c.read_limit) : fill;
        // delimiter read stops at the first match inside the limited window
        if (c.opcode == OP_READ_DELIM) begin
          idx = rd_ptr;
          for (int i = 0; i < n; i++) begin
            if (ring_mem[idx] == c.delimiter) begin
              n = i + 1;
              break;
            end
            idx = step_ptr(idx, cap);
          end
        end
        if (n == 0) begin
          pending_beats.push_back(count_beat(8'h00, 1'b0, 1'b1, cap));
        end else begin
          for (int i = 0; i < n; i++) begin
            taken[i] = ring_mem[rd_ptr];
            rd_ptr = step_ptr(rd_ptr, cap);
          end
          fill -= n;
          for (int i = 0; i < n; i++) begin
            pending_beats.push_back(count_beat(taken[i], 1'b1, i == n - 1, cap));
          end
        end
      end
    endcase
  endfunction

  function automatic void check_field(string name, int want_v, int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // monitor: checks the beat of this edge, then books the command and any
  // register write accepted at the same edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : beat_check
    obrb_res_t want;
    if (rst_ni) begin
      if (res_valid_o) begin
        if (pending_beats.size() == 0) begin
          $error("result beat with nothing pending: %p", res_o);
          errors++;
        end else begin
          want = pending_beats.pop_front();
          check_field("out_byte", want.out_byte, res_o.out_byte);
          check_field("byte_valid", want.byte_valid, res_o.byte_valid);
          check_field("last", want.last, res_o.last);
          check_field("used_count", want.used_count, res_o.used_count);
          check_field("free_count", want.free_count, res_o.free_count);
        end
      end
      if (start && !busy) predict_cmd(cmd_i);
      // a capacity write also empties the ring
      if (psel && penable && pwrite && pready && paddr == CAP_ADDR) begin
        cap_reg = pwdata[CNT_W-1:0];
        rd_ptr = 0;
        wr_ptr = 0;
        fill = 0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic obrb_in_t mk_cmd(obrb_op_e op, int data, int limit, int delim);
    obrb_in_t c;
    c.opcode     = op;
    c.data_byte  = 8'(data);
    c.read_limit = CNT_W'(limit);
    c.delimiter  = 8'(delim);
    return c;
  endfunction

  // small alphabet most of the time so delimiters actually hit
  function automatic int rand_byte();
    return ($urandom_range(0, 99) < 60) ? $urandom_range(0, 7) : $urandom_range(0, 255);
  endfunction

  // mostly none, some short, a few long
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic obrb_in_t rand_cmd(int cap);
    obrb_in_t c;
    int r;
    c.data_byte = 8'(rand_byte());
    c.delimiter = 8'(rand_byte());
    r = $urandom_range(0, 99);
    if (r < 8) c.read_limit = '0;
    else if (r < 16) c.read_limit = CNT_W'($urandom_range(0, 127));
    else c.read_limit = CNT_W'($urandom_range(1, cap + 2));
    r = $urandom_range(0, 99);
    if (r < 50) c.opcode = OP_WRITE;
    else if (r < 72) c.opcode = OP_READ;
    else if (r < 96) c.opcode = OP_READ_DELIM;
    else c.opcode = OP_PURGE;
    return c;
  endfunction

  // one command beat: optional idle gap, then hold start until accepted;
  // start is left high so back-to-back commands need no extra edge
  task automatic send_cmd(input obrb_in_t c, input int gap);
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // stop sending and wait until every pending beat is out and the block idles
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    do @(posedge clk_i); while (pending_beats.size() != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // apb write: setup phase, then access phase until pready
  task automatic write_capacity(input int v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= 32'(v);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // every opcode and the field extremes at the reset capacity, no idle gaps
  task automatic test_directed_ops();
    send_cmd(mk_cmd(OP_READ, 8'h5a, 5, 0), 0);            // read of empty ring
    send_cmd(mk_cmd(OP_READ_DELIM, 0, 127, 8'h00), 0);    // delimiter read of empty ring
    send_cmd(mk_cmd(OP_WRITE, 8'h00, 0, 8'hff), 0);
    send_cmd(mk_cmd(OP_WRITE, 8'hff, 127, 8'h00), 0);
    send_cmd(mk_cmd(OP_WRITE, 8'h55, 1, 8'haa), 0);
    send_cmd(mk_cmd(OP_WRITE, 8'haa, 64, 8'h55), 0);
    send_cmd(mk_cmd(OP_READ, 0, 0, 0), 0);                // zero limit, status only
    send_cmd(mk_cmd(OP_READ_DELIM, 0, 127, 8'hff), 0);    // match in the middle
    send_cmd(mk_cmd(OP_READ, 8'hff, 1, 8'hff), 0);        // single byte
    send_cmd(mk_cmd(OP_READ_DELIM, 0, 127, 8'h12), 0);    // no match, takes the rest
    send_cmd(mk_cmd(OP_WRITE, 8'h12, 3, 0), 0);
    send_cmd(mk_cmd(OP_WRITE, 8'h34, 3, 0), 0);
    send_cmd(mk_cmd(OP_WRITE, 8'h12, 3, 0), 0);
    send_cmd(mk_cmd(OP_READ_DELIM, 0, 64, 8'h12), 0);     // match on the first byte
    send_cmd(mk_cmd(OP_READ_DELIM, 0, 1, 8'h99), 0);      // limit cuts before any match
    send_cmd(mk_cmd(OP_READ_DELIM, 0, 0, 8'h12), 0);      // zero limit on delimiter read
    send_cmd(mk_cmd(OP_PURGE, 8'hff, 127, 8'hff), 0);     // purge with one byte held
    send_cmd(mk_cmd(OP_READ, 0, 127, 0), 0);              // nothing left after purge
    send_cmd(mk_cmd(OP_WRITE, 8'hc3, 0, 0), 0);
    send_cmd(mk_cmd(OP_READ_DELIM, 0, 1, 8'hc3), 0);      // match exactly at the limit
    send_cmd(mk_cmd(OP_PURGE, 0, 0, 0), 0);               // purge of an empty ring
    drain();
  endtask

  // capacity register corners: zero, tiny, above the depth, written while holding bytes
  task automatic test_capacity_edges();
    write_capacity(0);                                    // acts as one slot
    send_cmd(mk_cmd(OP_WRITE, 8'h11, 0, 0), idle_gap());
    send_cmd(mk_cmd(OP_WRITE, 8'h22, 0, 0), idle_gap());
    send_cmd(mk_cmd(OP_WRITE, 8'h33, 0, 0), idle_gap());
    send_cmd(mk_cmd(OP_READ, 0, 127, 0), idle_gap());
    send_cmd(mk_cmd(OP_READ, 0, 127, 0), idle_gap());
    drain();

    write_capacity(2);
    for (int i = 1; i <= 5; i++) send_cmd(mk_cmd(OP_WRITE, i, 0, 0), idle_gap());
    send_cmd(mk_cmd(OP_READ_DELIM, 0, 2, 5), idle_gap());
    drain();

    // above the depth: wrap the full store, overwrite, then one long read
    write_capacity(127);
    for (int i = 0; i < 70; i++) begin
      send_cmd(mk_cmd(OP_WRITE, $urandom_range(0, 255), 0, 0), idle_gap());
    end
    send_cmd(mk_cmd(OP_READ, 0, 127, 0), idle_gap());
    send_cmd(mk_cmd(OP_WRITE, 8'h7e, 0, 0), 0);
    send_cmd(mk_cmd(OP_WRITE, 8'h81, 0, 0), 0);
    drain();

    // a register write empties a ring that still holds bytes
    write_capacity(65);
    send_cmd(mk_cmd(OP_READ, 0, 127, 0), 0);
    drain();
    write_capacity(1);
    write_capacity(64);
    send_cmd(mk_cmd(OP_READ_DELIM, 0, 127, 0), 0);
    drain();
  endtask

  // random phases over several capacities; some phases run with no gaps
  task automatic test_random_traffic();
    int caps [8] = '{7, 64, 1, 20, 0, 127, 3, 45};
    int cap;
    int sent;
    int burst;
    int r;
    bit quiet;
    for (int p = 0; p < 8; p++) begin
      write_capacity(caps[p]);
      cap = (caps[p] == 0) ? 1 : ((caps[p] > DEPTH) ? DEPTH : caps[p]);
      quiet = (p == 2 || p == 5);
      sent = 0;
      while (sent < 40) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          // fill burst, can run past full to exercise overwrite
          burst = $urandom_range(1, cap + 3);
          for (int i = 0; i < burst; i++) begin
            send_cmd(mk_cmd(OP_WRITE, rand_byte(), $urandom_range(0, 127),
                            $urandom_range(0, 255)), quiet ? 0 : idle_gap());
          end
          sent += burst;
        end else if (r < 6) begin
          // hold off until all owed beats are out
          drain();
        end else begin
          send_cmd(rand_cmd(cap), quiet ? 0 : idle_gap());
          sent++;
        end
      end
      drain();
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni  = 1'b0;
    start   = 1'b0;
    cmd_i   = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed_ops();
    test_capacity_edges();
    test_random_traffic();
    drain();

    if (errors == 0) begin
      $display("[overwriting_byte_ring_buffer] OK");
    end else begin
      $display("[overwriting_byte_ring_buffer] ERROR");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #1_500_000;
    $display("[overwriting_byte_ring_buffer] ERROR");
    $finish;
  end

endmodule
